>>> src/fsd_pkg.sv
// ---------------------------------------------------------------------------
// fsd_pkg: shared definitions for the flux stream decoder
// Parser phase codes, event kinds, configuration register indexes and
// the stream byte codes for an end, a long interval or an opcode.
// ---------------------------------------------------------------------------
package fsd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] tick_t;
  typedef logic [27:0] value_t;

  // parser phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LONG   = 2'd1;
  localparam logic [1:0] PH_OPCODE = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  // event kinds
  localparam logic [2:0] EV_PULSE = 3'd0;
  localparam logic [2:0] EV_INDEX = 3'd1;
  localparam logic [2:0] EV_SPACE = 3'd2;
  localparam logic [2:0] EV_END   = 3'd3;
  localparam logic [2:0] EV_BAD   = 3'd4;

  // configuration register indexes
  localparam logic CFG_INDEX_OPCODE = 1'b0;
  localparam logic CFG_SPACE_OPCODE = 1'b1;

  localparam logic [7:0] INDEX_OPCODE_RST = 8'd1;
  localparam logic [7:0] SPACE_OPCODE_RST = 8'd2;

  // stream byte codes
  localparam logic [7:0] BYTE_END       = 8'd0;
  localparam logic [7:0] BYTE_LONG_BASE = 8'd250;
  localparam logic [7:0] BYTE_OPCODE    = 8'd255;

  // long code: 250 + high*255 + second - 1 = 249 + high*255 + second
  function automatic logic [10:0] long_base(input logic [2:0] high);
    logic [10:0] base;
    case (high)
      3'd0:    base = 11'd249;
      3'd1:    base = 11'd504;
      3'd2:    base = 11'd759;
      3'd3:    base = 11'd1014;
      3'd4:    base = 11'd1269;
      3'd5:    base = 11'd1524;
      3'd6:    base = 11'd1779;
      default: base = 11'd2034;
    endcase
    return base;
  endfunction

endpackage

>>> src/flux_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// flux_stream_decoder_core: byte-serial flux stream decoder
// Turns encoded flux bytes into pulse, index, space, end and error events.
// ---------------------------------------------------------------------------
// One stream byte per beat on the in_ channel, at most one event per byte
// on the out_ channel. The byte, the parser state and the tick counters
// go through the 32-bit adds and the compares into the output
// register, so a new byte is taken every cycle as long as the output
// register is empty or being drained in the same cycle. Bytes
// 1..249 give a pulse interval, 250..254 plus one more byte give a long
// interval, 255 starts an opcode byte and four value bytes (bits 7..1 of
// each, low byte first), 0 gives an end event. Ticks wrap modulo 2^32.
// The opcode registers are to be written on the cfg_ port only while the
// block is idle; the block itself does not enforce this, cfg_ready is always high.
// ---------------------------------------------------------------------------
module flux_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // stream bytes in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] stream_byte
  // events out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] event_value
  output logic [2:0]  out_tuser,   // [2:0] event_kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,   // 0 index_opcode, 1 space_opcode
  input  logic [7:0]  cfg_data
);

  // configuration
  fsd_pkg::byte_t index_opcode_r;
  fsd_pkg::byte_t space_opcode_r;

  // parser state
  logic [1:0]     phase_r,   phase_nxt;
  fsd_pkg::byte_t opcode_r,  opcode_nxt;
  logic [2:0]     high_r,    high_nxt;
  fsd_pkg::value_t gather_r, gather_nxt;
  logic [1:0]     count_r,   count_nxt;
  // running tick count and ticks since the last pulse
  // (the distance is kept instead of the last pulse tick: one add per path)
  fsd_pkg::tick_t tick_r,    tick_nxt;
  fsd_pkg::tick_t since_r,   since_nxt;

  // output register
  logic           out_valid_r;
  logic [2:0]     out_kind_r;
  fsd_pkg::tick_t out_value_r;

  logic           in_beat;
  logic           ev_valid;
  logic [2:0]     ev_kind;
  fsd_pkg::tick_t ev_value;

  fsd_pkg::byte_t  b;
  fsd_pkg::value_t gather_full;
  fsd_pkg::value_t byte_bits;
  fsd_pkg::tick_t  add_amt;
  fsd_pkg::tick_t  sum_tick;
  fsd_pkg::tick_t  sum_since;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;

  // place the seven value bits of this byte at the current group
  assign byte_bits = {21'd0, b[7:1]};
  always_comb begin
    case (count_r)
      2'd0:    gather_full = gather_r | byte_bits;
      2'd1:    gather_full = gather_r | (byte_bits << 7);
      2'd2:    gather_full = gather_r | (byte_bits << 14);
      default: gather_full = gather_r | (byte_bits << 21);
    endcase
  end

  // tick increment: gathered value in the value phase, else a pulse length
  always_comb begin
    if (phase_r == fsd_pkg::PH_VALUE) begin
      add_amt = {4'd0, gather_full};
    end else if (phase_r == fsd_pkg::PH_LONG) begin
      add_amt = {21'd0, fsd_pkg::long_base(high_r)} + {24'd0, b};
    end else begin
      add_amt = {24'd0, b};
    end
  end

  assign sum_tick  = tick_r + add_amt;
  assign sum_since = since_r + add_amt;

  // parser step
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    high_nxt   = high_r;
    gather_nxt = gather_r;
    count_nxt  = count_r;
    tick_nxt   = tick_r;
    since_nxt  = since_r;
    ev_valid   = 1'b0;
    ev_kind    = fsd_pkg::EV_PULSE;
    ev_value   = '0;
    case (phase_r)
      fsd_pkg::PH_LONG: begin
        phase_nxt = fsd_pkg::PH_IDLE;
        tick_nxt  = sum_tick;
        since_nxt = '0;
        ev_valid  = 1'b1;
        ev_kind   = fsd_pkg::EV_PULSE;
        ev_value  = sum_since;
      end
      fsd_pkg::PH_OPCODE: begin
        opcode_nxt = b;
        gather_nxt = '0;
        count_nxt  = 2'd0;
        phase_nxt  = fsd_pkg::PH_VALUE;
      end
      fsd_pkg::PH_VALUE: begin
        gather_nxt = gather_full;
        if (count_r != 2'd3) begin
          count_nxt = count_r + 2'd1;
        end else begin
          count_nxt = 2'd0;
          phase_nxt = fsd_pkg::PH_IDLE;
          ev_valid  = 1'b1;
          if (opcode_r == index_opcode_r) begin
            // absolute index position, tick count not advanced
            ev_kind  = fsd_pkg::EV_INDEX;
            ev_value = sum_tick;
          end else if (opcode_r == space_opcode_r) begin
            tick_nxt  = sum_tick;
            since_nxt = sum_since;
            ev_kind   = fsd_pkg::EV_SPACE;
            ev_value  = {4'd0, gather_full};
          end else begin
            ev_kind  = fsd_pkg::EV_BAD;
            ev_value = '0;
          end
        end
      end
      default: begin
        phase_nxt = fsd_pkg::PH_IDLE;
        if (b == fsd_pkg::BYTE_END) begin
          ev_valid = 1'b1;
          ev_kind  = fsd_pkg::EV_END;
          ev_value = '0;
        end else if (b == fsd_pkg::BYTE_OPCODE) begin
          phase_nxt = fsd_pkg::PH_OPCODE;
        end else if (b < fsd_pkg::BYTE_LONG_BASE) begin
          tick_nxt  = sum_tick;
          since_nxt = '0;
          ev_valid  = 1'b1;
          ev_kind   = fsd_pkg::EV_PULSE;
          ev_value  = sum_since;
        end else begin
          high_nxt  = 3'(b - fsd_pkg::BYTE_LONG_BASE);
          phase_nxt = fsd_pkg::PH_LONG;
        end
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_opcode_r <= fsd_pkg::INDEX_OPCODE_RST;
      space_opcode_r <= fsd_pkg::SPACE_OPCODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsd_pkg::CFG_INDEX_OPCODE: index_opcode_r <= cfg_data;
        default:                   space_opcode_r <= cfg_data;
      endcase
    end
  end

  // parser state, advanced once per input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fsd_pkg::PH_IDLE;
      opcode_r <= '0;
      high_r   <= '0;
      gather_r <= '0;
      count_r  <= '0;
      tick_r   <= '0;
      since_r  <= '0;
    end else if (in_beat) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      high_r   <= high_nxt;
      gather_r <= gather_nxt;
      count_r  <= count_nxt;
      tick_r   <= tick_nxt;
      since_r  <= since_nxt;
    end
  end

  // output register: loaded on an input beat, emptied when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= ev_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_kind_r  <= ev_kind;
      out_value_r <= ev_value;
    end
  end

endmodule

>>> dv/tb_flux_stream_decoder_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_flux_stream_decoder_core: self-checking bench for the flux stream decoder
// Feeds stream bytes with random gaps and output stalls, predicts every event
// from its own decoder state and compares each output beat field by field.
// ---------------------------------------------------------------------------
module tb_flux_stream_decoder_core;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BYTES  = 225;    // random bytes per config setting
  localparam int SETTLE_WAIT  = 4;      // output register plus margin
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]     kind;
    fsd_pkg::tick_t value;
  } flux_event_t;

  // DUT ports, inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = fsd_pkg::CFG_INDEX_OPCODE;
  logic [7:0]  cfg_data = 8'd0;

  flux_stream_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] stream_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [31:0] event_value
    .out_tuser  (out_tuser),    // [2:0] event_kind
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Decoder state as the bench sees it
  // -------------------------------------------------------------------------
  fsd_pkg::byte_t  idx_op_reg = fsd_pkg::INDEX_OPCODE_RST;
  fsd_pkg::byte_t  spc_op_reg = fsd_pkg::SPACE_OPCODE_RST;
  logic [1:0]      parse_ph = fsd_pkg::PH_IDLE;
  fsd_pkg::byte_t  op_pending = 8'd0;
  logic [2:0]      long_high = 3'd0;
  fsd_pkg::value_t value_acc = '0;
  logic [1:0]      value_cnt = 2'd0;
  fsd_pkg::tick_t  tick_now = '0;
  fsd_pkg::tick_t  last_pulse_at = '0;

  flux_event_t     event_q[$];     // events still owed by the DUT
  fsd_pkg::byte_t  stream_q[$];    // bytes waiting for the driver
  int              mismatches = 0;
  int              cycles = 0;

  // pacing, shared between the stimulus thread and the clocked blocks
  bit              in_burst = 1'b0;
  bit              out_burst = 1'b0;
  bit              in_busy = 1'b0;
  bit              in_fire_seen = 1'b0;
  bit              out_fire_seen = 1'b0;
  int              in_gap = 0;
  int              out_stall = 0;
  fsd_pkg::byte_t  in_byte = 8'd0;

  task automatic owe_event(input logic [2:0] kind, input fsd_pkg::tick_t value);
    flux_event_t ev;
    ev.kind  = kind;
    ev.value = value;
    event_q.push_back(ev);
  endtask

  task automatic owe_pulse(input fsd_pkg::tick_t add);
    tick_now = tick_now + add;
    owe_event(fsd_pkg::EV_PULSE, tick_now - last_pulse_at);
    last_pulse_at = tick_now;
  endtask

  // advance the decoder state by one accepted stream byte
  task automatic decode_byte(input fsd_pkg::byte_t b);
    fsd_pkg::value_t next_acc;
    case (parse_ph)
      fsd_pkg::PH_LONG: begin
        parse_ph = fsd_pkg::PH_IDLE;
        owe_pulse(fsd_pkg::tick_t'(250) + fsd_pkg::tick_t'(long_high) * 255
                  + fsd_pkg::tick_t'(b) - 1);
      end
      fsd_pkg::PH_OPCODE: begin
        op_pending = b;
        value_acc  = '0;
        value_cnt  = 2'd0;
        parse_ph   = fsd_pkg::PH_VALUE;
      end
      fsd_pkg::PH_VALUE: begin
        next_acc  = value_acc | (fsd_pkg::value_t'(b[7:1]) << (7 * value_cnt));
        value_acc = next_acc;
        if (value_cnt != 2'd3) begin
          value_cnt = value_cnt + 2'd1;
        end else begin
          value_cnt = 2'd0;
          parse_ph  = fsd_pkg::PH_IDLE;
          // index wins when both registers hold the same opcode
          if (op_pending == idx_op_reg) begin
            owe_event(fsd_pkg::EV_INDEX, tick_now + fsd_pkg::tick_t'(value_acc));
          end else if (op_pending == spc_op_reg) begin
            tick_now = tick_now + fsd_pkg::tick_t'(value_acc);
            owe_event(fsd_pkg::EV_SPACE, fsd_pkg::tick_t'(value_acc));
          end else begin
            owe_event(fsd_pkg::EV_BAD, '0);
          end
        end
      end
      default: begin
        parse_ph = fsd_pkg::PH_IDLE;
        if (b == fsd_pkg::BYTE_END) begin
          owe_event(fsd_pkg::EV_END, '0);
        end else if (b == fsd_pkg::BYTE_OPCODE) begin
          parse_ph = fsd_pkg::PH_OPCODE;
        end else if (b < fsd_pkg::BYTE_LONG_BASE) begin
          owe_pulse(fsd_pkg::tick_t'(b));
        end else begin
          long_high = 3'(b - fsd_pkg::BYTE_LONG_BASE);
          parse_ph  = fsd_pkg::PH_LONG;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input fsd_pkg::tick_t want,
                               input fsd_pkg::tick_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch %s at cycle %0d: expected %0h, got %0h", what, cycles, want, got);
  endtask

  task automatic check_event(input logic [2:0] kind, input fsd_pkg::tick_t value);
    flux_event_t want;
    if (event_q.size() == 0) begin
      note_mismatch("unexpected event kind", '0, fsd_pkg::tick_t'(kind));
    end else begin
      want = event_q.pop_front();
      if (kind !== want.kind)
        note_mismatch("event_kind", fsd_pkg::tick_t'(want.kind), fsd_pkg::tick_t'(kind));
      if (value !== want.value)
        note_mismatch("event_value", want.value, value);
    end
  endtask

  // -------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL flux_stream_decoder_core");
      $finish;
    end
    if (rst_n) begin
      // an output beat always belongs to an older byte, so check first
      if (out_tvalid && out_tready) begin
        check_event(out_tuser, out_tdata);
        out_fire_seen = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        in_fire_seen = 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Byte driver: one beat in flight, random gap before each byte
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_fire_seen) begin
      in_fire_seen = 1'b0;
      in_busy      = 1'b0;
    end
    if (rst_n && !in_busy) begin
      if (in_gap != 0) begin
        in_gap--;
      end else if (stream_q.size() != 0) begin
        in_byte = stream_q.pop_front();
        in_busy = 1'b1;
        in_gap  = in_burst ? 0 : $urandom_range(0, 13);
      end
    end
    in_tvalid <= in_busy;
    in_tdata  <= in_byte;
  end

  // Event sink: random stall after each beat taken
  always @(negedge clk) begin
    if (out_fire_seen) begin
      out_fire_seen = 1'b0;
      out_stall     = out_burst ? 0 : $urandom_range(0, 13);
    end
    if (out_stall != 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input fsd_pkg::byte_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == fsd_pkg::CFG_INDEX_OPCODE) idx_op_reg = val;
    else                                  spc_op_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued byte is taken and every owed event has come
  task automatic drain;
    while (stream_q.size() != 0 || in_busy || event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // finish any half-parsed code so a register write cannot split one
  task automatic drain_to_idle;
    drain();
    while (parse_ph != fsd_pkg::PH_IDLE) begin
      stream_q.push_back(8'd1);
      drain();
    end
  endtask

  task automatic push_long(input int high, input fsd_pkg::byte_t second);
    stream_q.push_back(fsd_pkg::byte_t'(fsd_pkg::BYTE_LONG_BASE + high));
    stream_q.push_back(second);
  endtask

  // 255, opcode, then 7 value bits per byte, low first; bit 0 is filler
  task automatic push_op(input fsd_pkg::byte_t op, input fsd_pkg::value_t val);
    stream_q.push_back(fsd_pkg::BYTE_OPCODE);
    stream_q.push_back(op);
    for (int i = 0; i < 4; i++)
      stream_q.push_back({val[7*i +: 7], 1'($urandom)});
  endtask

  task automatic push_random_record(input fsd_pkg::byte_t idx_op,
                                    input fsd_pkg::byte_t spc_op);
    int              pick;
    fsd_pkg::byte_t  op;
    fsd_pkg::value_t val;
    pick = $urandom_range(0, 99);
    // small values most of the time, now and then a full 28-bit one
    val = ($urandom_range(0, 3) == 0) ? fsd_pkg::value_t'($urandom)
                                      : fsd_pkg::value_t'($urandom_range(0, 2000));
    case ($urandom_range(0, 4))
      0, 1:    op = idx_op;
      2, 3:    op = spc_op;
      default: op = fsd_pkg::byte_t'($urandom);
    endcase
    if (pick < 40) begin
      stream_q.push_back(fsd_pkg::byte_t'($urandom_range(1, 249)));
    end else if (pick < 55) begin
      push_long($urandom_range(0, 4), fsd_pkg::byte_t'($urandom));
    end else if (pick < 75) begin
      push_op(op, val);
    end else if (pick < 80) begin
      stream_q.push_back(fsd_pkg::BYTE_END);
    end else if (pick < 85) begin
      // opcode code cut short; whatever follows lands in its value bytes
      stream_q.push_back(fsd_pkg::BYTE_OPCODE);
      stream_q.push_back(op);
    end else begin
      stream_q.push_back(fsd_pkg::byte_t'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    fsd_pkg::byte_t idx_set;
    fsd_pkg::byte_t spc_set;
    int             start_len;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes under the reset opcodes
    in_burst  = 1'b1;
    out_burst = 1'b1;
    stream_q.push_back(8'd1);
    stream_q.push_back(8'd249);
    push_long(0, 8'd0);                       // shortest long interval
    push_long(4, 8'd255);                     // longest long interval
    stream_q.push_back(fsd_pkg::BYTE_END);
    stream_q.push_back(fsd_pkg::BYTE_OPCODE); // index, largest value, filler bits set
    stream_q.push_back(fsd_pkg::INDEX_OPCODE_RST);
    repeat (4) stream_q.push_back(8'hFF);
    stream_q.push_back(fsd_pkg::BYTE_OPCODE); // space of zero
    stream_q.push_back(fsd_pkg::SPACE_OPCODE_RST);
    repeat (4) stream_q.push_back(8'h00);
    push_op(8'h77, fsd_pkg::value_t'(28'h5A5A5A5));  // unknown opcode
    drain_to_idle();

    // then random traffic under several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idx_set = 8'd0;   spc_set = 8'd255; end
        1: begin idx_set = 8'd255; spc_set = 8'd0;   end
        2: begin idx_set = fsd_pkg::byte_t'($urandom); spc_set = idx_set; end
        3: begin
          idx_set = fsd_pkg::byte_t'($urandom);
          spc_set = fsd_pkg::byte_t'($urandom);
        end
        default: begin
          idx_set = fsd_pkg::INDEX_OPCODE_RST;
          spc_set = fsd_pkg::SPACE_OPCODE_RST;
        end
      endcase
      write_reg(fsd_pkg::CFG_INDEX_OPCODE, idx_set);
      write_reg(fsd_pkg::CFG_SPACE_OPCODE, spc_set);
      in_burst  = (ph % 3 == 1);
      out_burst = (ph % 3 == 2);
      start_len = 0;
      while (start_len < PHASE_BYTES) begin
        int before_len;
        before_len = stream_q.size();
        push_random_record(idx_set, spc_set);
        start_len += stream_q.size() - before_len;
        // keep the driver queue short so pacing changes take hold quickly
        while (stream_q.size() > 16) @(posedge clk);
      end
      drain_to_idle();
    end

    drain();
    if (mismatches == 0 && event_q.size() == 0) begin
      $display("PASS flux_stream_decoder_core");
    end else begin
      $display("FAIL flux_stream_decoder_core");
    end
    $finish;
  end

endmodule
